// File: sv/fpr_pkg.sv
// shared types and constants for the framed packet receiver
// no dependencies; imported by every module of the block
package fpr_pkg;

  localparam logic [2:0] HEAD_LEN   = 3'd4;
  localparam logic [1:0] TAIL_LEN   = 2'd3;
  localparam logic [6:0] SIZE_RESET = 7'd64;

  // header bytes in order
  function automatic logic [7:0] head_mark(input logic [1:0] idx);
    logic [7:0] mark;
    case (idx)
      2'd0:    mark = 8'h46;
      2'd1:    mark = 8'h4C;
      2'd2:    mark = 8'h45;
      2'd3:    mark = 8'h58;
      default: mark = 8'h46;
    endcase
    return mark;
  endfunction

  // trailer bytes in order
  function automatic logic [7:0] tail_mark(input logic [1:0] idx);
    logic [7:0] mark;
    case (idx)
      2'd0:    mark = 8'h3C;
      2'd1:    mark = 8'h21;
      2'd2:    mark = 8'h3E;
      default: mark = 8'h3C;
    endcase
    return mark;
  endfunction

  typedef enum logic [1:0] {
    B_IDLE,
    B_SEND
  } back_state_t;

  // buffer bank handed back by the drain side
  typedef struct packed {
    logic done;
    logic bank;
  } fpr_rel_t;

endpackage

// File: sv/framed_packet_receiver_unit.sv
// top level of the framed packet receiver: front parser, frame queue, drain
// depends on fpr_pkg, fpr_front, fpr_queue, fpr_back
//
// usage:
//   s_* carries received bytes, one word per handshake; m_* carries the
//   payload of each frame that passes its checksum, m_tlast on its final word.
//   cfg_* writes payload_size (7 bits, saturated to MAX_PAYLOAD); write it
//   only while no frame is in flight. cfg_ready is high out of reset.
//   the front takes one byte per cycle while s_tready is high; a frame's words
//   appear on m_* after its checksum byte is taken, then one word per cycle while
//   m_tready is high. payload is kept in two buffer banks, so one frame can be
//   drained while the next is received. s_tready drops on a payload or
//   checksum byte only while both banks still hold frames not yet sent.
//   a stalled m_tready holds the current word in the output register.
//   reset (rst, synchronous) clears the parser, the queue and the output,
//   and sets payload_size to 64; buffer contents are not cleared.
module framed_packet_receiver_unit
  import fpr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] payload_byte
  output logic       m_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [6:0]    payload_size;
  logic          q_full;
  logic          q_push;
  logic [CW:0]   q_in;
  logic          q_valid;
  logic [CW:0]   q_head;
  logic          q_pop;
  fpr_rel_t      rel;
  logic          wr_en;
  logic          wr_bank;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_size <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      payload_size <= cfg_data;
    end
  end

  fpr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .CW          (CW),
    .AW          (AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_byte      (s_tdata),
    .payload_size (payload_size),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in),
    .rel          (rel),
    .wr_en        (wr_en),
    .wr_bank      (wr_bank),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  fpr_queue #(
    .W (CW + 1)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head),
    .full       (q_full)
  );

  fpr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .CW          (CW),
    .AW          (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .rel       (rel),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// File: sv/fpr_queue.sv
// two-entry queue of finished frames (bank and length) between front and back
// depends on fpr_pkg
module fpr_queue
  import fpr_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data,
  output logic         full
);

  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic [1:0]   count_next;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head_data  = entry[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// File: sv/fpr_front.sv
// front side: takes received bytes, tracks header/payload/trailer/checksum,
// writes payload into the free buffer bank and queues finished frames; uses fpr_pkg
module fpr_front
  import fpr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64,
  parameter int CW = 7,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic [6:0]    payload_size,
  input  logic          q_full,
  output logic          q_push,
  output logic [CW:0]   q_data,
  input  fpr_rel_t      rel,
  output logic          wr_en,
  output logic          wr_bank,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  logic [2:0]    hdr_cnt;
  logic [1:0]    trl_cnt;
  logic [CW-1:0] data_cnt;
  logic [7:0]    sum;
  logic          wb;
  logic [1:0]    busy;

  logic [2:0]    hdr_cnt_next;
  logic [1:0]    trl_cnt_next;
  logic [CW-1:0] data_cnt_next;
  logic [7:0]    sum_next;
  logic          wb_next;
  logic [1:0]    busy_next;

  logic [6:0] eff_size;
  logic [6:0] cnt7;
  logic       in_head;
  logic       in_data;
  logic       over;
  logic       in_trail;
  logic       in_sum;
  logic       take;

  always_comb begin
    eff_size = (payload_size > 7'(MAX_PAYLOAD)) ? 7'(MAX_PAYLOAD) : payload_size;
    cnt7     = 7'(data_cnt);
    in_head  = (hdr_cnt < HEAD_LEN);
    in_data  = !in_head && (cnt7 < eff_size);
    over     = !in_head && (cnt7 > eff_size);
    in_trail = !in_head && !in_data && !over && (trl_cnt < TAIL_LEN);
    in_sum   = !in_head && !in_data && !over && !in_trail;
  end

  // hold off a payload byte until its bank is drained, and a checksum byte while the queue is full
  assign in_ready = !rst && !(in_data && busy[wb]) && !(in_sum && q_full);
  assign take     = in_valid && in_ready;

  assign wr_en   = take && in_data;
  assign wr_bank = wb;
  assign wr_addr = data_cnt[AW-1:0];
  assign wr_data = in_byte;
  assign q_data  = {wb, data_cnt};

  always_comb begin
    hdr_cnt_next  = hdr_cnt;
    trl_cnt_next  = trl_cnt;
    data_cnt_next = data_cnt;
    sum_next      = sum;
    wb_next       = wb;
    q_push        = 1'b0;
    busy_next     = busy;
    if (rel.done) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (take) begin
      if (in_head) begin
        if (in_byte == head_mark(hdr_cnt[1:0])) begin
          hdr_cnt_next = hdr_cnt + 3'd1;
        end else begin
          hdr_cnt_next = 3'd0;
        end
      end else if (in_data) begin
        data_cnt_next = data_cnt + CW'(1);
        sum_next      = sum + in_byte;
      end else if (in_trail && (in_byte == tail_mark(trl_cnt))) begin
        trl_cnt_next = trl_cnt + 2'd1;
      end else begin
        // bad trailer byte, size shrunk mid-frame, or checksum byte
        if (in_sum && (in_byte == sum) && (data_cnt != '0)) begin
          q_push        = 1'b1;
          busy_next[wb] = 1'b1;
          wb_next       = ~wb;
        end
        hdr_cnt_next  = 3'd0;
        trl_cnt_next  = 2'd0;
        data_cnt_next = '0;
        sum_next      = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_cnt  <= 3'd0;
      trl_cnt  <= 2'd0;
      data_cnt <= '0;
      sum      <= 8'd0;
      wb       <= 1'b0;
      busy     <= 2'b00;
    end else begin
      hdr_cnt  <= hdr_cnt_next;
      trl_cnt  <= trl_cnt_next;
      data_cnt <= data_cnt_next;
      sum      <= sum_next;
      wb       <= wb_next;
      busy     <= busy_next;
    end
  end

endmodule

// File: sv/fpr_back.sv
// back side: two-bank payload buffer and the drain that sends a queued frame
// as a run of words with a registered output; uses fpr_pkg
module fpr_back
  import fpr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64,
  parameter int CW = 7,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic          wr_bank,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          q_valid,
  input  logic [CW:0]   q_data,
  output logic          q_pop,
  output fpr_rel_t      rel,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  logic [7:0] mem [2][MAX_PAYLOAD];
  logic [7:0] rdata;

  back_state_t   state;
  back_state_t   state_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_next;
  logic          rd_en;
  logic [CW-1:0] rd_idx;
  logic          load;
  logic          is_last;
  logic          head_bank;
  logic [CW-1:0] head_len;

  assign head_bank = q_data[CW];
  assign head_len  = q_data[CW-1:0];
  assign is_last   = ((idx + CW'(1)) == head_len);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    rd_en      = 1'b0;
    rd_idx     = idx;
    load       = 1'b0;
    q_pop      = 1'b0;
    rel        = '{done: 1'b0, bank: head_bank};
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          rd_en      = 1'b1;
          rd_idx     = '0;
          idx_next   = '0;
          state_next = B_SEND;
        end
      end
      B_SEND: begin
        if (!out_valid || out_ready) begin
          load = 1'b1;
          if (is_last) begin
            q_pop      = 1'b1;
            rel.done   = 1'b1;
            idx_next   = '0;
            state_next = B_IDLE;
          end else begin
            // fetch the following word while this one moves out
            idx_next = idx + CW'(1);
            rd_en    = 1'b1;
            rd_idx   = idx + CW'(1);
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bank][wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[head_bank][rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= rdata;
      out_last <= is_last;
    end
  end

endmodule

// File: sv/fpr_checker.sv
// port-level checks for framed_packet_receiver_unit, attached by bind
// depends on fpr_pkg and the top level's ports
module fpr_checker
  import fpr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       cfg_ready
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // reset empties the output and leaves the parser waiting for a header
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid && (rst || s_tready))
    else $error("output or input side not idle after reset");

  // the config channel never stalls outside reset
  a_cfg_ready: assert property (@(posedge clk)
    !rst |-> cfg_ready)
    else $error("config channel stalled");

  // no word goes out in the cycle right after reset
  a_no_early_out: assert property (@(posedge clk)
    $fell(rst) |-> !m_tvalid)
    else $error("word shown right after reset");

endmodule

bind framed_packet_receiver_unit fpr_checker u_fpr_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .cfg_ready (cfg_ready)
);
